// File: rtl/length_prefix_deframer_defines.svh
// Assertion macros for the deframer RTL.
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
`default_nettype none

package lpd_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned HEADER_BYTES_DEF = 2;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 2;

  localparam logic [LEN_W-1:0]      MAX_LEN_RESET    = 16'd4096;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_MSG_LEN = 2'd0;

  // Command codes on the input channel
  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_last;
    logic              message_ready;
    logic [LEN_W-1:0]  message_length;
    logic              error;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/lpd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
`default_nettype none

interface lpd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [lpd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface lpd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       payload_valid;
  logic [lpd_pkg::BYTE_W-1:0] payload_byte;
  logic                       payload_last;
  logic                       message_ready;
  logic [lpd_pkg::LEN_W-1:0]  message_length;
  logic                       error;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_last, output message_ready, output message_length,
                  output error, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_last, input message_ready, input message_length,
                  input error, output ready);
endinterface

`default_nettype wire

// File: rtl/length_prefix_deframer.sv
// Length-prefix deframer: big-endian length header, streamed payload, error detect.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+-----------------------------------------
//  in_ch    | in  | valid/ready      | cmd, data_byte
//  out_ch   | out | valid/ready      | payload_valid/byte/last, message_ready,
//           |     |                  | message_length, error
//  apb      | in  | psel/penable     | max_message_length at address 0
//
//  One transfer per cycle in each direction while out_ch is not stalled; a result
//  appears in the cycle after its input transfer, from the output register.
//  Per-byte work is 16-bit compares and one 16-bit increment on frame state.
//  in_ch.ready is high while the output register is empty or being drained,
//  so a stalled sink holds exactly one result and stalls the input.
//  rst (synchronous) clears frame state and the output valid flag, and sets the
//  maximum length to 4096.
`default_nettype none

`include "length_prefix_deframer_defines.svh"

module length_prefix_deframer #(
  parameter int unsigned HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lpd_in_if.sink                              in_ch,
  lpd_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam logic [HCW-1:0] HDR_FULL = HCW'(HEADER_BYTES);
  localparam logic [HCW-1:0] HDR_LAST = HCW'(HEADER_BYTES - 1);

  // Frame state
  logic [HCW-1:0]            header_count, header_count_next;
  logic [lpd_pkg::LEN_W-1:0] expected_length, expected_length_next;
  logic [lpd_pkg::LEN_W-1:0] received_length, received_length_next;
  logic [lpd_pkg::LEN_W-1:0] max_message_length;

  // Output register
  lpd_pkg::result_t res, res_next;
  logic             out_valid;

  logic in_fire;
  logic cfg_write;
  logic [lpd_pkg::LEN_W-1:0] len_shifted;
  logic [lpd_pkg::LEN_W-1:0] rcv_inc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == lpd_pkg::ADDR_MAX_MSG_LEN);
  assign prdata    = (paddr == lpd_pkg::ADDR_MAX_MSG_LEN)
                   ? lpd_pkg::APB_DATA_W'(max_message_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_message_length <= pwdata[lpd_pkg::LEN_W-1:0];
    end
  end

  // Per-byte decode: next frame state and the result item
  assign len_shifted = {expected_length[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], in_ch.data_byte};
  assign rcv_inc     = received_length + lpd_pkg::LEN_W'(1);

  always_comb begin
    header_count_next    = header_count;
    expected_length_next = expected_length;
    received_length_next = received_length;
    res_next             = '0;
    if (lpd_pkg::cmd_t'(in_ch.cmd) == lpd_pkg::CMD_CLEAR) begin
      header_count_next    = '0;
      expected_length_next = '0;
      received_length_next = '0;
    end else if (header_count < HDR_FULL) begin
      // header byte, most significant first
      expected_length_next = len_shifted;
      header_count_next    = header_count + HCW'(1);
      if (header_count == HDR_LAST) begin
        if (len_shifted > max_message_length) begin
          res_next.error       = 1'b1;
          header_count_next    = '0;
          expected_length_next = '0;
          received_length_next = '0;
        end else if (len_shifted == '0) begin
          res_next.message_ready = 1'b1;
        end
      end
    end else if (received_length >= expected_length) begin
      // overrun: data after a complete message
      res_next.error       = 1'b1;
      header_count_next    = '0;
      expected_length_next = '0;
      received_length_next = '0;
    end else begin
      res_next.payload_valid = 1'b1;
      res_next.payload_byte  = in_ch.data_byte;
      received_length_next   = rcv_inc;
      if (rcv_inc == expected_length) begin
        res_next.payload_last   = 1'b1;
        res_next.message_ready  = 1'b1;
        res_next.message_length = expected_length;
      end
    end
  end

  // State update on input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      expected_length <= '0;
      received_length <= '0;
    end else if (in_fire) begin
      header_count    <= header_count_next;
      expected_length <= expected_length_next;
      received_length <= received_length_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.payload_valid  = res.payload_valid;
  assign out_ch.payload_byte   = res.payload_byte;
  assign out_ch.payload_last   = res.payload_last;
  assign out_ch.message_ready  = res.message_ready;
  assign out_ch.message_length = res.message_length;
  assign out_ch.error          = res.error;

  // Checks
  `LPD_ASSERT_NOW(a_hdr_bound, 1'b1, header_count <= HDR_FULL, "header count past header size")
  `LPD_ASSERT_NOW(a_rcv_bound, header_count == HDR_FULL, received_length <= expected_length,
                  "received more payload than announced")
  `LPD_ASSERT_NEXT(a_err_clears, in_fire && res_next.error,
                   header_count == '0 && received_length == '0, "error did not clear frame state")
  `LPD_ASSERT_NOW(a_flags_excl, out_valid && res.error,
                  !res.payload_valid && !res.message_ready, "error result carries other flags")
  `LPD_ASSERT_NOW(a_last_ready, out_valid && res.payload_last,
                  res.payload_valid && res.message_ready, "last byte without message ready")

endmodule

`default_nettype wire

// File: bench/tb_length_prefix_deframer.sv
// Self-checking testbench for the length-prefix deframer: predicted results, random traffic, APB setup.
`timescale 1ns / 100ps

module tb_length_prefix_deframer;

  localparam int unsigned HDR_BYTES = lpd_pkg::HEADER_BYTES_DEF;
  localparam int RANDOM_PER_PHASE = 320;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_PHASES = 5;

  // One pending input transfer
  typedef struct packed {
    lpd_pkg::cmd_t              cmd;
    logic [lpd_pkg::BYTE_W-1:0] data;
  } stream_item_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [lpd_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [lpd_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lpd_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  length_prefix_deframer u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  stream_item_t      stream_bytes[$];
  lpd_pkg::result_t  predicted_results[$];
  int                mismatch_count = 0;
  int                items_queued = 0;
  int                cycle_count = 0;
  int                gen_max;

  // Predictor state: frame progress and the programmed maximum
  logic [1:0]                hdr_seen = '0;
  logic [lpd_pkg::LEN_W-1:0] announced_len = '0;
  logic [lpd_pkg::LEN_W-1:0] received_len = '0;
  logic [lpd_pkg::LEN_W-1:0] max_len_cfg = lpd_pkg::MAX_LEN_RESET;

  // Handshake bookkeeping for the drivers
  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;

  function automatic void clear_frame();
    hdr_seen = '0;
    announced_len = '0;
    received_len = '0;
  endfunction

  // Next result of the deframer for one accepted stream byte
  function automatic lpd_pkg::result_t deframe_byte(lpd_pkg::cmd_t c,
                                                    logic [lpd_pkg::BYTE_W-1:0] b);
    lpd_pkg::result_t r;
    r = '0;
    if (c == lpd_pkg::CMD_CLEAR) begin
      clear_frame();
    end else if (hdr_seen < HDR_BYTES) begin
      announced_len = {announced_len[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], b};
      hdr_seen = hdr_seen + 2'd1;
      if (hdr_seen >= HDR_BYTES) begin
        if (announced_len > max_len_cfg) begin
          r.error = 1'b1;
          clear_frame();
        end else if (announced_len == '0) begin
          r.message_ready = 1'b1;
        end
      end
    end else if (received_len >= announced_len) begin
      // overrun: byte after a complete message
      r.error = 1'b1;
      clear_frame();
    end else begin
      r.payload_valid = 1'b1;
      r.payload_byte = b;
      received_len = received_len + 16'd1;
      if (received_len == announced_len) begin
        r.payload_last = 1'b1;
        r.message_ready = 1'b1;
        r.message_length = announced_len;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [lpd_pkg::LEN_W-1:0] want,
                                      logic [lpd_pkg::LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // No gap unless the pct draw hits; then mostly short gaps, a few long ones
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 4))
      0, 1: return 0;
      2: return 15;
      3: return 40;
      default: return 70;
    endcase
  endfunction

  // Input driver: presents the next pending byte once the previous one transferred
  always @(negedge clk) begin : drive_input
    stream_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (stream_bytes.size() > 0) begin
        nxt = stream_bytes.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nxt.cmd;
        in_ch.data_byte <= nxt.data;
        if ($urandom_range(0, 199) == 0) in_idle_pct <= pick_idle_pct();
        in_gap <= pick_gap(in_idle_pct);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) out_idle_pct <= pick_idle_pct();
      out_stall <= pick_gap(out_idle_pct);
    end
  end

  // Monitor: predict on input transfer, compare on result transfer
  always @(posedge clk) begin : monitor
    lpd_pkg::result_t got;
    lpd_pkg::result_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.insert(predicted_results.size(),
                                 deframe_byte(lpd_pkg::cmd_t'(in_ch.cmd), in_ch.data_byte));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{payload_valid: out_ch.payload_valid, payload_byte: out_ch.payload_byte,
                payload_last: out_ch.payload_last, message_ready: out_ch.message_ready,
                message_length: out_ch.message_length, error: out_ch.error};
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, actual %p",
                   $time, got);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("payload_valid", lpd_pkg::LEN_W'(want.payload_valid),
                      lpd_pkg::LEN_W'(got.payload_valid));
          check_field("payload_byte", lpd_pkg::LEN_W'(want.payload_byte),
                      lpd_pkg::LEN_W'(got.payload_byte));
          check_field("payload_last", lpd_pkg::LEN_W'(want.payload_last),
                      lpd_pkg::LEN_W'(got.payload_last));
          check_field("message_ready", lpd_pkg::LEN_W'(want.message_ready),
                      lpd_pkg::LEN_W'(got.message_ready));
          check_field("message_length", want.message_length, got.message_length);
          check_field("error", lpd_pkg::LEN_W'(want.error), lpd_pkg::LEN_W'(got.error));
        end
      end
    end
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_item(input lpd_pkg::cmd_t c, input logic [lpd_pkg::BYTE_W-1:0] b);
    stream_item_t it;
    it.cmd = c;
    it.data = b;
    stream_bytes.insert(stream_bytes.size(), it);
    items_queued++;
  endtask

  task automatic push_header(input logic [lpd_pkg::LEN_W-1:0] len);
    push_item(lpd_pkg::CMD_DATA, len[15:8]);
    push_item(lpd_pkg::CMD_DATA, len[7:0]);
  endtask

  task automatic push_payload(input int n);
    repeat (n) push_item(lpd_pkg::CMD_DATA, lpd_pkg::BYTE_W'($urandom));
  endtask

  task automatic push_frame(input int len);
    push_header(lpd_pkg::LEN_W'(len));
    push_payload(len);
  endtask

  // Legal payload length, mostly small
  function automatic int pick_length(int max_len);
    int r;
    int cap;
    if (max_len == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20 && max_len <= 300) return max_len;
    cap = (r < 85) ? 24 : 300;
    if (cap > max_len) cap = max_len;
    return $urandom_range(1, cap);
  endfunction

  // One random scenario: clean frames dominate, then errors and noise
  task automatic queue_random_traffic();
    int r;
    int len;
    int room;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      if ($urandom_range(0, 9) < 8) push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
      push_frame(pick_length(gen_max));
    end else if (r < 75) begin
      // oversize header, or a random header and payload when the maximum is 65535
      push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
      if (gen_max == 65535) begin
        push_header(lpd_pkg::LEN_W'($urandom));
        push_payload($urandom_range(0, 5));
        push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
      end else begin
        room = 65534 - gen_max;
        if (room > 200) room = 200;
        if ($urandom_range(0, 3) == 0) push_header(16'hFFFF);
        else push_header(lpd_pkg::LEN_W'(gen_max + 1 + $urandom_range(0, room)));
      end
    end else if (r < 85) begin
      // truncated frame
      push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
      len = pick_length(gen_max);
      push_header(lpd_pkg::LEN_W'(len));
      if (len > 0) push_payload($urandom_range(0, len - 1));
      if ($urandom_range(0, 1) == 0) push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
    end else if (r < 92) begin
      // complete frame followed by overrun bytes
      push_item(lpd_pkg::CMD_CLEAR, lpd_pkg::BYTE_W'($urandom));
      push_frame(pick_length(gen_max));
      push_payload($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        push_item(($urandom_range(0, 4) == 0) ? lpd_pkg::CMD_CLEAR : lpd_pkg::CMD_DATA,
                  lpd_pkg::BYTE_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (stream_bytes.size() != 0 || in_ch.valid || predicted_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the maximum length, then read it back
  task automatic program_max_length(input logic [lpd_pkg::LEN_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lpd_pkg::ADDR_MAX_MSG_LEN;
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    max_len_cfg = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== lpd_pkg::APB_DATA_W'(value)) begin
      $display("%0t: max_message_length readback, expected %0h, actual %0h",
               $time, value, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int phase_max[NUM_PHASES];
    int target;
    in_ch.valid = 1'b0;
    in_ch.cmd = lpd_pkg::CMD_DATA;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    phase_max[0] = 4096;
    phase_max[1] = 0;
    phase_max[2] = 65535;
    phase_max[3] = 1;
    phase_max[4] = $urandom_range(2, 300);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks under the reset maximum
    gen_max = 4096;
    @(posedge clk);
    push_item(lpd_pkg::CMD_CLEAR, 8'hFF);      // clear ignores its data byte
    push_header(16'h0000);                     // zero length completes at once
    push_item(lpd_pkg::CMD_DATA, 8'h5A);       // overrun after completion
    push_header(16'h0001);
    push_item(lpd_pkg::CMD_DATA, 8'hFF);       // single byte message
    push_item(lpd_pkg::CMD_CLEAR, 8'h00);
    push_header(16'h1001);                     // one above the maximum
    push_header(16'hFFFF);                     // largest header value
    push_item(lpd_pkg::CMD_DATA, 8'h10);       // clear in the middle of a header
    push_item(lpd_pkg::CMD_CLEAR, 8'h3C);
    push_header(16'h0003);
    push_item(lpd_pkg::CMD_DATA, 8'h00);
    push_item(lpd_pkg::CMD_DATA, 8'h80);
    push_item(lpd_pkg::CMD_DATA, 8'h7F);
    push_item(lpd_pkg::CMD_DATA, 8'h00);       // overrun, state cleared
    push_header(16'h0002);                     // header right after an overrun
    push_item(lpd_pkg::CMD_DATA, 8'h01);
    push_item(lpd_pkg::CMD_DATA, 8'hFE);
    push_item(lpd_pkg::CMD_CLEAR, 8'h00);
    wait_drained();

    // Random phases, each under its own maximum
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_max_length(lpd_pkg::LEN_W'(phase_max[p]));
      gen_max = phase_max[p];
      @(posedge clk);
      // one message announcing exactly the maximum length
      push_item(lpd_pkg::CMD_CLEAR, 8'h00);
      if (gen_max <= 300) begin
        push_frame(gen_max);
      end else begin
        push_header(lpd_pkg::LEN_W'(gen_max));
        push_payload(50);
        push_item(lpd_pkg::CMD_CLEAR, 8'h00);
      end
      target = items_queued + RANDOM_PER_PHASE;
      while (items_queued < target) queue_random_traffic();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: length_prefix_deframer.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/length_prefix_deframer.sv
bench/tb_length_prefix_deframer.sv
